// ===== design/pmg_pkg.sv =====
package pmg_pkg;

    localparam int Width      = 64;
    localparam int MulSteps   = 64;
    localparam int DivSteps   = 63;
    localparam int CntWidth   = $clog2(MulSteps);

    typedef enum logic [1:0] {
        MODE_POW    = 2'd0,
        MODE_MODPOW = 2'd1,
        MODE_GCD    = 2'd2,
        MODE_BAD    = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_REDUCE,
        S_BASE,
        S_TEST,
        S_MUL_ACC,
        S_WB_ACC,
        S_MUL_SQ,
        S_WB_BASE,
        S_GCD_TEST,
        S_GCD_DIV,
        S_GCD_WB,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DIV_INIT_MOD,
        DP_DIV_STEP,
        DP_BASE_FROM_REM,
        DP_MUL_ACC_INIT,
        DP_MUL_SQ_INIT,
        DP_MUL_STEP,
        DP_WB_ACC,
        DP_WB_BASE,
        DP_DIV_INIT_GCD,
        DP_GCD_WB,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_mode mode;
        logic  mod_zero;
        logic  exp_zero;
        logic  exp_lsb;
        logic  cnt_mul_last;
        logic  cnt_div_last;
        logic  out_free;
    } t_status;

    // keep the low Width bits and sign-extend them to 64
    function automatic logic [63:0] wrap_to_width(input logic [63:0] v);
        logic [63:0] w;
        for (int i = 0; i < 64; i++) begin
            w[i] = (i < Width) ? v[i] : v[Width-1];
        end
        return w;
    endfunction

endpackage

// ===== design/pmg_ctrl.sv =====
module pmg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pmg_pkg::t_status i_status,
    output logic             o_in_stall,
    output pmg_pkg::t_dp_op  o_op
);

    pmg_pkg::t_state r_state;
    pmg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != pmg_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmg_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pmg_pkg::S_SETUP;
            end
            pmg_pkg::S_SETUP: begin
                unique case (i_status.mode)
                    pmg_pkg::MODE_POW:    n_state = pmg_pkg::S_TEST;
                    pmg_pkg::MODE_MODPOW: n_state = i_status.mod_zero ? pmg_pkg::S_DONE
                                                                       : pmg_pkg::S_REDUCE;
                    pmg_pkg::MODE_GCD:    n_state = pmg_pkg::S_GCD_TEST;
                    pmg_pkg::MODE_BAD:    n_state = pmg_pkg::S_DONE;
                endcase
            end
            pmg_pkg::S_REDUCE: begin
                if (i_status.cnt_div_last) n_state = pmg_pkg::S_BASE;
            end
            pmg_pkg::S_BASE: n_state = pmg_pkg::S_TEST;
            pmg_pkg::S_TEST: begin
                priority if (i_status.exp_zero) n_state = pmg_pkg::S_DONE;
                else if (i_status.exp_lsb)      n_state = pmg_pkg::S_MUL_ACC;
                else                            n_state = pmg_pkg::S_MUL_SQ;
            end
            pmg_pkg::S_MUL_ACC: begin
                if (i_status.cnt_mul_last) n_state = pmg_pkg::S_WB_ACC;
            end
            pmg_pkg::S_WB_ACC: n_state = pmg_pkg::S_MUL_SQ;
            pmg_pkg::S_MUL_SQ: begin
                if (i_status.cnt_mul_last) n_state = pmg_pkg::S_WB_BASE;
            end
            pmg_pkg::S_WB_BASE: n_state = pmg_pkg::S_TEST;
            pmg_pkg::S_GCD_TEST: begin
                n_state = i_status.exp_zero ? pmg_pkg::S_DONE : pmg_pkg::S_GCD_DIV;
            end
            pmg_pkg::S_GCD_DIV: begin
                if (i_status.cnt_div_last) n_state = pmg_pkg::S_GCD_WB;
            end
            pmg_pkg::S_GCD_WB: n_state = pmg_pkg::S_GCD_TEST;
            pmg_pkg::S_DONE: begin
                if (i_status.out_free) n_state = pmg_pkg::S_IDLE;
            end
            default: n_state = pmg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_op = pmg_pkg::DP_NOP;
        unique case (r_state)
            pmg_pkg::S_IDLE: begin
                if (i_in_valid) o_op = pmg_pkg::DP_LOAD;
            end
            pmg_pkg::S_SETUP: begin
                if (i_status.mode == pmg_pkg::MODE_MODPOW && !i_status.mod_zero) begin
                    o_op = pmg_pkg::DP_DIV_INIT_MOD;
                end
            end
            pmg_pkg::S_REDUCE:  o_op = pmg_pkg::DP_DIV_STEP;
            pmg_pkg::S_BASE:    o_op = pmg_pkg::DP_BASE_FROM_REM;
            pmg_pkg::S_TEST: begin
                priority if (i_status.exp_zero) o_op = pmg_pkg::DP_NOP;
                else if (i_status.exp_lsb)      o_op = pmg_pkg::DP_MUL_ACC_INIT;
                else                            o_op = pmg_pkg::DP_MUL_SQ_INIT;
            end
            pmg_pkg::S_MUL_ACC: o_op = pmg_pkg::DP_MUL_STEP;
            pmg_pkg::S_WB_ACC:  o_op = pmg_pkg::DP_WB_ACC;
            pmg_pkg::S_MUL_SQ:  o_op = pmg_pkg::DP_MUL_STEP;
            pmg_pkg::S_WB_BASE: o_op = pmg_pkg::DP_WB_BASE;
            pmg_pkg::S_GCD_TEST: begin
                if (!i_status.exp_zero) o_op = pmg_pkg::DP_DIV_INIT_GCD;
            end
            pmg_pkg::S_GCD_DIV: o_op = pmg_pkg::DP_DIV_STEP;
            pmg_pkg::S_GCD_WB:  o_op = pmg_pkg::DP_GCD_WB;
            pmg_pkg::S_DONE: begin
                if (i_status.out_free) o_op = pmg_pkg::DP_FINISH;
            end
            default: o_op = pmg_pkg::DP_NOP;
        endcase
    end

endmodule

// ===== design/pmg_dp.sv =====
module pmg_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pmg_pkg::t_dp_op      i_op,
    input  logic [1:0]           i_mode,
    input  logic [62:0]          i_first_operand,
    input  logic [62:0]          i_second_operand,
    input  logic [62:0]          i_modulus,
    input  logic                 i_out_stall,
    output pmg_pkg::t_status     o_status,
    output logic                 o_out_valid,
    output logic signed [63:0]   o_result,
    output logic                 o_error
);

    pmg_pkg::t_mode                r_mode;
    logic [63:0]                   r_acc;
    logic [63:0]                   r_base;
    logic [62:0]                   r_exp;
    logic [62:0]                   r_mod;
    logic [63:0]                   r_pa;
    logic [63:0]                   r_ma;
    logic [63:0]                   r_mb;
    logic [62:0]                   r_rem;
    logic [62:0]                   r_dq;
    logic [62:0]                   r_dv;
    logic [pmg_pkg::CntWidth-1:0]  r_cnt;
    logic                          r_out_valid;
    logic [63:0]                   r_result;
    logic                          r_error;

    logic [63:0] div_t;
    logic [64:0] div_d;
    logic [62:0] div_rem;
    logic [64:0] mul_s;
    logic [65:0] mul_t1;
    logic [65:0] mul_t2;
    logic [63:0] mul_next;
    logic [63:0] fin_result;
    logic        fin_error;
    logic        mod_zero;

    assign mod_zero = (r_mod == '0);

    // one restoring remainder step
    always_comb begin
        div_t   = {r_rem, r_dq[62]};
        div_d   = {1'b0, div_t} - {2'b00, r_dv};
        div_rem = div_d[64] ? div_t[62:0] : div_d[62:0];
    end

    // one double-and-add step, reduced by up to twice the modulus in modpow mode
    always_comb begin
        mul_s  = {r_pa, 1'b0} + (r_mb[63] ? {1'b0, r_ma} : 65'd0);
        mul_t1 = {1'b0, mul_s} - {3'b000, r_mod};
        mul_t2 = {1'b0, mul_s} - {2'b00, r_mod, 1'b0};
        if (r_mode == pmg_pkg::MODE_MODPOW) begin
            priority if (!mul_t2[65]) mul_next = mul_t2[63:0];
            else if (!mul_t1[65])     mul_next = mul_t1[63:0];
            else                      mul_next = mul_s[63:0];
        end else begin
            mul_next = mul_s[63:0];
        end
    end

    always_comb begin
        fin_result = '0;
        fin_error  = 1'b0;
        unique case (r_mode)
            pmg_pkg::MODE_POW:    fin_result = pmg_pkg::wrap_to_width(r_acc);
            pmg_pkg::MODE_MODPOW: begin
                fin_result = mod_zero ? 64'd0 : r_acc;
                fin_error  = mod_zero;
            end
            pmg_pkg::MODE_GCD:    fin_result = {1'b0, r_base[62:0]};
            pmg_pkg::MODE_BAD:    fin_error  = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            pmg_pkg::DP_NOP: begin
            end
            pmg_pkg::DP_LOAD: begin
                r_mode <= pmg_pkg::t_mode'(i_mode);
                r_base <= {1'b0, i_first_operand};
                r_exp  <= i_second_operand;
                r_mod  <= i_modulus;
                r_acc  <= (i_mode == pmg_pkg::MODE_MODPOW && i_modulus == 63'd1) ? 64'd0
                                                                                  : 64'd1;
            end
            pmg_pkg::DP_DIV_INIT_MOD: begin
                r_rem <= '0;
                r_dq  <= r_base[62:0];
                r_dv  <= r_mod;
                r_cnt <= '0;
            end
            pmg_pkg::DP_DIV_STEP: begin
                r_rem <= div_rem;
                r_dq  <= {r_dq[61:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            pmg_pkg::DP_BASE_FROM_REM: begin
                r_base <= {1'b0, r_rem};
            end
            pmg_pkg::DP_MUL_ACC_INIT: begin
                r_pa  <= '0;
                r_ma  <= r_acc;
                r_mb  <= r_base;
                r_cnt <= '0;
            end
            pmg_pkg::DP_MUL_SQ_INIT: begin
                r_pa  <= '0;
                r_ma  <= r_base;
                r_mb  <= r_base;
                r_cnt <= '0;
            end
            pmg_pkg::DP_MUL_STEP: begin
                r_pa  <= mul_next;
                r_mb  <= {r_mb[62:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            pmg_pkg::DP_WB_ACC: begin
                r_acc <= r_pa;
                r_pa  <= '0;
                r_ma  <= r_base;
                r_mb  <= r_base;
                r_cnt <= '0;
            end
            pmg_pkg::DP_WB_BASE: begin
                r_base <= r_pa;
                r_exp  <= {1'b0, r_exp[62:1]};
            end
            pmg_pkg::DP_DIV_INIT_GCD: begin
                r_rem <= '0;
                r_dq  <= r_base[62:0];
                r_dv  <= r_exp;
                r_cnt <= '0;
            end
            pmg_pkg::DP_GCD_WB: begin
                r_base <= {1'b0, r_exp};
                r_exp  <= r_rem;
            end
            pmg_pkg::DP_FINISH: begin
                r_result <= fin_result;
                r_error  <= fin_error;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == pmg_pkg::DP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_status.mode         = r_mode;
        o_status.mod_zero     = mod_zero;
        o_status.exp_zero     = (r_exp == '0);
        o_status.exp_lsb      = r_exp[0];
        o_status.cnt_mul_last = (r_cnt == pmg_pkg::CntWidth'(pmg_pkg::MulSteps - 1));
        o_status.cnt_div_last = (r_cnt == pmg_pkg::CntWidth'(pmg_pkg::DivSteps - 1));
        o_status.out_free     = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_error     = r_error;

endmodule

// ===== design/power_modpow_gcd_unit.sv =====
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_stall    i_mode, i_first_operand, i_second_operand,
//                                                i_modulus
// out      output     o_out_valid / i_out_stall  o_result, o_error
//
// one item at a time; the input stalls from acceptance until the result is registered
// power modes: per exponent bit, a multiply into the accumulator when the bit is set, then a
// square, each a 64-step pass on one shared double-and-add unit, plus a base reduction in mode 1
// gcd: each euclid step runs on a 63-step restoring remainder unit
// synchronous active-low reset clears the controller and the output valid
// a stalled result holds in the output register while the next item is accepted
module power_modpow_gcd_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_mode,
    input  logic [62:0]         i_first_operand,
    input  logic [62:0]         i_second_operand,
    input  logic [62:0]         i_modulus,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [63:0]  o_result,
    output logic                o_error
);

    pmg_pkg::t_status status;
    pmg_pkg::t_dp_op  op;

    pmg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_op       (op)
    );

    pmg_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_mode           (i_mode),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_modulus        (i_modulus),
        .i_out_stall      (i_out_stall),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_result         (o_result),
        .o_error          (o_error)
    );

endmodule
